@@ rtl/core/stx_etx_frame_receiver_ring_defines.svh @@
// assertion macros for the stx/etx frame receiver checker
// no dependencies; included by the checker file
`ifndef STX_ETX_FRAME_RECEIVER_RING_DEFINES_SVH
`define STX_ETX_FRAME_RECEIVER_RING_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SXR_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sxr check failed");

// next-cycle implication, sampled on clk, off during reset
`define SXR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sxr check failed");

`endif

@@ rtl/core/sxr_pkg.sv @@
// shared constants, types and codes of the stx/etx frame receiver
// no dependencies; imported by every module of the block but sxr_ram
package sxr_pkg;

    // ring geometry
    localparam int SLOT_COUNT      = 8;
    localparam int MAX_FRAME_BYTES = 64;
    localparam int SLOT_W          = $clog2(SLOT_COUNT);
    localparam int LEN_W           = $clog2(MAX_FRAME_BYTES + 1);
    localparam int FRAME_DEPTH     = SLOT_COUNT * MAX_FRAME_BYTES;
    localparam int FADDR_W         = $clog2(FRAME_DEPTH);

    // port field widths
    localparam int BYTE_W    = 8;
    localparam int FLEN_W    = 7;
    localparam int SIDX_W    = 3;
    localparam int CFG_IDX_W = 2;

    // queue sizes
    localparam int CQ_DEPTH = 2;
    localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
    localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    // marker reset values
    localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'h02;
    localparam logic [BYTE_W-1:0] END_MARKER_RST   = 8'h03;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_MARKER = 2'd0,
        REG_END_MARKER   = 2'd1
    } cfg_reg_t;

    // result event codes
    typedef enum logic [2:0] {
        EV_BYTE        = 3'd0,
        EV_COMMIT      = 3'd1,
        EV_OVERFLOW    = 3'd2,
        EV_FULL        = 3'd3,
        EV_EMPTY_RING  = 3'd4,
        EV_EMPTY_FRAME = 3'd5
    } event_t;

    // classified word kinds
    typedef enum logic [1:0] {
        KIND_DATA,
        KIND_START,
        KIND_END,
        KIND_TAKE
    } kind_t;

    // back-end sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LEN,
        ST_STREAM
    } state_t;

    // classified word between front and back
    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] data;
    } cmd_t;

    // one result word
    typedef struct packed {
        event_t            ev;
        logic [BYTE_W-1:0] data;
        logic [FLEN_W-1:0] len;
        logic [SIDX_W-1:0] slot;
        logic              last;
    } res_t;

endpackage

@@ rtl/core/sxr_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
module sxr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/sxr_front.sv @@
// front end: marker registers, word classification and the command queue
// depends on sxr_pkg
module sxr_front import sxr_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic                 command,
    input  logic [BYTE_W-1:0]    rx_byte,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data,
    output cmd_t                 cq_head,
    output logic                 cq_valid,
    input  logic                 cq_pop
);

    logic [BYTE_W-1:0]   start_marker_reg;
    logic [BYTE_W-1:0]   end_marker_reg;
    cmd_t                cq_mem_reg [CQ_DEPTH];
    logic [CQ_PTR_W-1:0] wr_ptr_reg;
    logic [CQ_PTR_W-1:0] rd_ptr_reg;
    logic [CQ_CNT_W-1:0] cnt_reg;
    cmd_t                cmd_in;
    logic                do_push;
    logic                do_pop;

    assign cfg_ready = 1'b1;

    // marker registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg <= START_MARKER_RST;
            end_marker_reg   <= END_MARKER_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_START_MARKER: start_marker_reg <= cfg_data;
                REG_END_MARKER:   end_marker_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    // classify the incoming word, end marker wins over start marker
    always_comb
    begin
        cmd_in.data = rx_byte;
        priority if (command)
            cmd_in.kind = KIND_TAKE;
        else if (rx_byte == end_marker_reg)
            cmd_in.kind = KIND_END;
        else if (rx_byte == start_marker_reg)
            cmd_in.kind = KIND_START;
        else
            cmd_in.kind = KIND_DATA;
    end

    // command queue
    assign full     = (cnt_reg == CQ_CNT_W'(CQ_DEPTH));
    assign cq_valid = (cnt_reg != '0);
    assign cq_head  = cq_mem_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = cq_pop && cq_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            cq_mem_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

@@ rtl/core/sxr_outq.sv @@
// result queue that decouples the back end from the receiver
// depends on sxr_pkg
module sxr_outq import sxr_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                oq_push,
    input  res_t                oq_res,
    output logic [OQ_CNT_W-1:0] oq_count,
    output logic                empty,
    input  logic                pop,
    output res_t                head
);

    res_t                mem_reg [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] wr_ptr_reg;
    logic [OQ_PTR_W-1:0] rd_ptr_reg;
    logic [OQ_CNT_W-1:0] cnt_reg;
    logic                do_pop;

    assign empty    = (cnt_reg == '0);
    assign oq_count = cnt_reg;
    assign head     = mem_reg[rd_ptr_reg];
    assign do_pop   = pop && !empty;

    // storage, the back end only pushes when there is room
    always_ff @(posedge clk)
    begin
        if (oq_push)
        begin
            mem_reg[wr_ptr_reg] <= oq_res;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (oq_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (oq_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !oq_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

@@ rtl/core/sxr_back.sv @@
// back end: frame assembly, ring bookkeeping and frame streaming
// depends on sxr_pkg and sxr_ram (frame store and slot lengths)
module sxr_back import sxr_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cq_head,
    input  logic                cq_valid,
    output logic                cq_pop,
    input  logic [OQ_CNT_W-1:0] oq_count,
    output logic                oq_push,
    output res_t                oq_res
);

    state_t              state_reg, state_next;
    logic [SLOT_W-1:0]   ws_reg, ws_next;
    logic [SLOT_W-1:0]   rs_reg, rs_next;
    logic                collecting_reg, collecting_next;
    logic                allowed_reg, allowed_next;
    logic [LEN_W-1:0]    cur_len_reg, cur_len_next;
    logic [LEN_W-1:0]    take_len_reg, take_len_next;
    logic [SLOT_W-1:0]   take_slot_reg, take_slot_next;
    logic [LEN_W-1:0]    idx_reg, idx_next;
    logic                pend_reg, pend_next;
    logic                pend_last_reg, pend_last_next;

    logic                len_we;
    logic [LEN_W-1:0]    len_rdata;
    logic                frm_we;
    logic [FADDR_W-1:0]  frm_waddr;
    logic [FADDR_W-1:0]  frm_raddr;
    logic [BYTE_W-1:0]   frm_rdata;

    logic                space;
    logic [SLOT_W-1:0]   ws_inc;
    logic [SLOT_W-1:0]   rs_inc;
    logic                ring_room;

    // one result slot must remain per word in flight from the frame store
    assign space = ((OQ_CNT_W + 1)'(oq_count) + (OQ_CNT_W + 1)'(pend_reg))
                   < (OQ_CNT_W + 1)'(OQ_DEPTH);

    // ring index arithmetic
    assign ws_inc    = (ws_reg == SLOT_W'(SLOT_COUNT - 1)) ? '0 : ws_reg + 1'b1;
    assign rs_inc    = (rs_reg == SLOT_W'(SLOT_COUNT - 1)) ? '0 : rs_reg + 1'b1;
    assign ring_room = (ws_inc != rs_reg);

    // frame store addressing
    assign frm_waddr = FADDR_W'(ws_reg) * FADDR_W'(MAX_FRAME_BYTES) + FADDR_W'(cur_len_reg);
    assign frm_raddr = FADDR_W'(take_slot_reg) * FADDR_W'(MAX_FRAME_BYTES)
                       + FADDR_W'(idx_reg);

    sxr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (FRAME_DEPTH)
    ) u_frame_store (
        .clk   (clk),
        .we    (frm_we),
        .waddr (frm_waddr),
        .wdata (cq_head.data),
        .raddr (frm_raddr),
        .rdata (frm_rdata)
    );

    // slot lengths, written on commit, read at the oldest slot
    sxr_ram #(
        .WIDTH (LEN_W),
        .DEPTH (SLOT_COUNT)
    ) u_slot_lengths (
        .clk   (clk),
        .we    (len_we),
        .waddr (ws_reg),
        .wdata (cur_len_reg),
        .raddr (rs_reg),
        .rdata (len_rdata)
    );

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            ws_reg         <= '0;
            rs_reg         <= '0;
            collecting_reg <= 1'b0;
            allowed_reg    <= 1'b1;
            pend_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ws_reg         <= ws_next;
            rs_reg         <= rs_next;
            collecting_reg <= collecting_next;
            allowed_reg    <= allowed_next;
            pend_reg       <= pend_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_len_reg   <= cur_len_next;
        take_len_reg  <= take_len_next;
        take_slot_reg <= take_slot_next;
        idx_reg       <= idx_next;
        pend_last_reg <= pend_last_next;
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        ws_next         = ws_reg;
        rs_next         = rs_reg;
        collecting_next = collecting_reg;
        allowed_next    = allowed_reg;
        cur_len_next    = cur_len_reg;
        take_len_next   = take_len_reg;
        take_slot_next  = take_slot_reg;
        idx_next        = idx_reg;
        pend_next       = 1'b0;
        pend_last_next  = pend_last_reg;
        cq_pop          = 1'b0;
        len_we          = 1'b0;
        frm_we          = 1'b0;
        oq_push         = 1'b0;
        oq_res.ev       = EV_BYTE;
        oq_res.data     = '0;
        oq_res.len      = FLEN_W'(cur_len_reg);
        oq_res.slot     = SIDX_W'(ws_reg);
        oq_res.last     = 1'b1;

        // frame byte read last cycle goes out now
        if (pend_reg)
        begin
            oq_push     = 1'b1;
            oq_res.ev   = EV_BYTE;
            oq_res.data = frm_rdata;
            oq_res.len  = FLEN_W'(take_len_reg);
            oq_res.slot = SIDX_W'(take_slot_reg);
            oq_res.last = pend_last_reg;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cq_valid && !pend_reg && space)
                begin
                    cq_pop = 1'b1;
                    unique case (cq_head.kind)
                        KIND_TAKE:
                        begin
                            if (rs_reg == ws_reg)
                            begin
                                oq_push     = 1'b1;
                                oq_res.ev   = EV_EMPTY_RING;
                                oq_res.len  = '0;
                                oq_res.slot = SIDX_W'(rs_reg);
                            end
                            else
                            begin
                                take_slot_next = rs_reg;
                                state_next     = ST_LEN;
                            end
                        end
                        KIND_END:
                        begin
                            collecting_next = 1'b0;
                            allowed_next    = ring_room;
                            if (collecting_reg)
                            begin
                                oq_push   = 1'b1;
                                oq_res.ev = ring_room ? EV_COMMIT : EV_FULL;
                                if (ring_room)
                                begin
                                    len_we  = 1'b1;
                                    ws_next = ws_inc;
                                end
                            end
                        end
                        KIND_START:
                        begin
                            if (allowed_reg)
                            begin
                                cur_len_next    = '0;
                                collecting_next = 1'b1;
                            end
                        end
                        KIND_DATA:
                        begin
                            if (collecting_reg)
                            begin
                                if (cur_len_reg < LEN_W'(MAX_FRAME_BYTES))
                                begin
                                    frm_we       = 1'b1;
                                    cur_len_next = cur_len_reg + 1'b1;
                                end
                                else
                                begin
                                    collecting_next = 1'b0;
                                    oq_push         = 1'b1;
                                    oq_res.ev       = EV_OVERFLOW;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_LEN:
            begin
                // slot length of the oldest frame is valid here
                if (len_rdata == '0)
                begin
                    if (space)
                    begin
                        oq_push     = 1'b1;
                        oq_res.ev   = EV_EMPTY_FRAME;
                        oq_res.len  = '0;
                        oq_res.slot = SIDX_W'(take_slot_reg);
                        rs_next     = rs_inc;
                        state_next  = ST_IDLE;
                    end
                end
                else
                begin
                    take_len_next = len_rdata;
                    idx_next      = '0;
                    state_next    = ST_STREAM;
                end
            end
            ST_STREAM:
            begin
                // issue one frame store read per cycle while results have room
                if (space)
                begin
                    pend_next      = 1'b1;
                    pend_last_next = (idx_reg + 1'b1 == take_len_reg);
                    idx_next       = idx_reg + 1'b1;
                    if (idx_reg + 1'b1 == take_len_reg)
                    begin
                        rs_next    = rs_inc;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/stx_etx_frame_receiver_ring.sv @@
// Top level of the STX/ETX frame receiver with a ring of frame slots.
// Words enter on push/full: command 0 carries a received line byte in rx_byte,
// command 1 asks for the oldest committed frame. Results leave on empty/pop,
// one word per result with event_res, data_byte, frame_length, slot_index and
// last_of_run; last_of_run marks the final result caused by an input word.
// Markers are set on the cfg_* write channel (index 0 start, 1 end), which is
// always ready. Write them only while no word is in flight.
// A line byte is handled by the back end and gives at most one result; it
// is registered in the command queue and then in the result queue before
// empty goes low. A take fetches the slot length, then streams one frame
// byte per cycle out of the frame store read port while results have room.
// A two-word command queue and a four-word result queue sit between the
// sides, so input is taken while results wait. When the receiver holds off
// pop, the result queue fills, the back end stops and full eventually rises.
// Reset empties both queues, clears the ring to no frames and restores the
// marker values 0x02 and 0x03; frame store and slot lengths are not cleared.
// depends on sxr_pkg, sxr_front, sxr_back, sxr_outq
module stx_etx_frame_receiver_ring import sxr_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic                 command,
    input  logic [BYTE_W-1:0]    rx_byte,
    output logic                 empty,
    input  logic                 pop,
    output logic [2:0]           event_res,
    output logic [BYTE_W-1:0]    data_byte,
    output logic [FLEN_W-1:0]    frame_length,
    output logic [SIDX_W-1:0]    slot_index,
    output logic                 last_of_run,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data
);

    cmd_t                cq_head;
    logic                cq_valid;
    logic                cq_pop;
    logic [OQ_CNT_W-1:0] oq_count;
    logic                oq_push;
    res_t                oq_res;
    res_t                head;

    // front end
    sxr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .command   (command),
        .rx_byte   (rx_byte),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cq_head   (cq_head),
        .cq_valid  (cq_valid),
        .cq_pop    (cq_pop)
    );

    // back end
    sxr_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cq_head  (cq_head),
        .cq_valid (cq_valid),
        .cq_pop   (cq_pop),
        .oq_count (oq_count),
        .oq_push  (oq_push),
        .oq_res   (oq_res)
    );

    // result queue
    sxr_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .oq_push  (oq_push),
        .oq_res   (oq_res),
        .oq_count (oq_count),
        .empty    (empty),
        .pop      (pop),
        .head     (head)
    );

    // result word fields
    assign event_res    = head.ev;
    assign data_byte    = head.data;
    assign frame_length = head.len;
    assign slot_index   = head.slot;
    assign last_of_run  = head.last;

endmodule

@@ rtl/core/sxr_checker.sv @@
// port-level checks of the stx/etx frame receiver, bound to the top level
// depends on sxr_pkg and stx_etx_frame_receiver_ring_defines.svh
`include "stx_etx_frame_receiver_ring_defines.svh"

module sxr_checker import sxr_pkg::*; (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 empty,
    input logic                 pop,
    input logic [2:0]           event_res,
    input logic [BYTE_W-1:0]    data_byte,
    input logic [FLEN_W-1:0]    frame_length,
    input logic [SIDX_W-1:0]    slot_index,
    input logic                 last_of_run
);

    // a waiting result holds until taken
    `SXR_ASSERT_NEXT(a_head_holds, !empty && !pop, !empty && $stable(event_res) && $stable(data_byte) && $stable(frame_length) && $stable(slot_index))

    // every result other than a frame byte ends its run
    `SXR_ASSERT_IMP(a_single_is_last, !empty && event_res != EV_BYTE, last_of_run)

    // only frame bytes carry data
    `SXR_ASSERT_IMP(a_data_only_bytes, !empty && event_res != EV_BYTE, data_byte == '0)

    // empty ring and empty frame report no length
    `SXR_ASSERT_IMP(a_empty_no_len, !empty && (event_res == EV_EMPTY_RING || event_res == EV_EMPTY_FRAME), frame_length == '0)

endmodule

bind stx_etx_frame_receiver_ring sxr_checker u_sxr_checker (.*);

@@ sim/tb_top.sv @@
// testbench for the stx/etx frame receiver ring: random and directed line words,
// a cycle-free predictor of the deframer and an in-order result checker
// depends on sxr_pkg and stx_etx_frame_receiver_ring
`timescale 1ns / 100ps

module tb_top;
    import sxr_pkg::*;

    localparam int IDLE_LIMIT     = 2000;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES  = 20;
    localparam int DRAIN_CYCLES   = 100;

    // one word offered on the input side
    typedef struct {
        logic              cmd;
        logic [BYTE_W-1:0] value;
    } line_word_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 push = 1'b0;
    logic                 full;
    logic                 command = 1'b0;
    logic [BYTE_W-1:0]    rx_byte = '0;
    logic                 empty;
    logic                 pop = 1'b0;
    logic [2:0]           event_res;
    logic [BYTE_W-1:0]    data_byte;
    logic [FLEN_W-1:0]    frame_length;
    logic [SIDX_W-1:0]    slot_index;
    logic                 last_of_run;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    cfg_reg_t             cfg_index = REG_START_MARKER;
    logic [BYTE_W-1:0]    cfg_data = '0;

    // deframer state as predicted
    logic [BYTE_W-1:0] frame_bytes [SLOT_COUNT][MAX_FRAME_BYTES];
    int                slot_len [SLOT_COUNT];
    int                wr_slot = 0;
    int                rd_slot = 0;
    bit                in_frame = 1'b0;
    bit                rx_enabled = 1'b1;
    logic [BYTE_W-1:0] start_mk = START_MARKER_RST;
    logic [BYTE_W-1:0] end_mk = END_MARKER_RST;

    // expected result words, oldest first
    res_t       pending_results[$];
    line_word_t tx_words[$];

    int words_queued = 0;
    int words_taken = 0;
    int err_count = 0;
    int send_gap = 0;
    int pop_gap = 0;
    int hold_left = 0;
    int idle_cycles = 0;
    bit hold_request = 1'b0;
    bit hold_done = 1'b0;
    bit quiet_tail = 1'b0;

    stx_etx_frame_receiver_ring uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .command      (command),
        .rx_byte      (rx_byte),
        .empty        (empty),
        .pop          (pop),
        .event_res    (event_res),
        .data_byte    (data_byte),
        .frame_length (frame_length),
        .slot_index   (slot_index),
        .last_of_run  (last_of_run),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic flag_error(string msg);
        if (err_count < 50)
            $display("mismatch at %0t ns: %s", $time, msg);
        err_count++;
    endtask

    // deframer behavior for one accepted word; appends the results it causes
    function automatic void deframe_step(logic cmd, logic [BYTE_W-1:0] b);
        int   ws;
        int   rs;
        int   len;
        int   i;
        bit   was_open;
        res_t r;
        ws = wr_slot;
        rs = rd_slot;
        r = '0;
        r.last = 1'b1;
        if (cmd) begin
            r.slot = rs[SIDX_W-1:0];
            if (rs == ws) begin
                r.ev = EV_EMPTY_RING;
                pending_results.push_back(r);
                return;
            end
            len = slot_len[rs];
            rd_slot = (rs + 1) % SLOT_COUNT;
            if (len == 0) begin
                r.ev = EV_EMPTY_FRAME;
                pending_results.push_back(r);
                return;
            end
            r.ev = EV_BYTE;
            r.len = len[FLEN_W-1:0];
            for (i = 0; i < len; i++) begin
                r.data = frame_bytes[rs][i];
                r.last = (i + 1 == len);
                pending_results.push_back(r);
            end
            return;
        end
        r.slot = ws[SIDX_W-1:0];
        if (b == end_mk) begin
            was_open = in_frame;
            r.len = slot_len[ws][FLEN_W-1:0];
            in_frame = 1'b0;
            if ((ws + 1) % SLOT_COUNT != rs) begin
                rx_enabled = 1'b1;
                if (was_open) begin
                    wr_slot = (ws + 1) % SLOT_COUNT;
                    r.ev = EV_COMMIT;
                    pending_results.push_back(r);
                end
            end else begin
                rx_enabled = 1'b0;
                if (was_open) begin
                    r.ev = EV_FULL;
                    pending_results.push_back(r);
                end
            end
        end else if (b == start_mk) begin
            if (rx_enabled) begin
                slot_len[ws] = 0;
                in_frame = 1'b1;
            end
        end else if (in_frame) begin
            len = slot_len[ws];
            if (len < MAX_FRAME_BYTES) begin
                frame_bytes[ws][len] = b;
                slot_len[ws] = len + 1;
            end else begin
                in_frame = 1'b0;
                r.ev = EV_OVERFLOW;
                r.len = len[FLEN_W-1:0];
                pending_results.push_back(r);
            end
        end
    endfunction

    // input driver: offers queued words, predicts on acceptance
    always @(posedge clk)
    begin : word_driver
        line_word_t w;
        if (rst_n) begin
            if (push && !full) begin
                deframe_step(command, rx_byte);
                words_taken++;
            end
            if (push && full) begin
                // hold the word until the block takes it
            end else if (send_gap != 0) begin
                send_gap--;
                push <= 1'b0;
            end else if (tx_words.size() != 0) begin
                if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                    send_gap = $urandom_range(0, 9);
                    push <= 1'b0;
                end else begin
                    w = tx_words.pop_front();
                    push <= 1'b1;
                    command <= w.cmd;
                    rx_byte <= w.value;
                end
            end else begin
                push <= 1'b0;
            end
        end
    end

    // result monitor: checks each accepted result and paces pop
    always @(posedge clk)
    begin : result_monitor
        res_t want;
        if (rst_n) begin
            if (pop && !empty) begin
                if (pending_results.size() == 0) begin
                    flag_error("result word with nothing expected");
                end else begin
                    want = pending_results.pop_front();
                    if (event_res !== want.ev)
                        flag_error($sformatf("event_res %0d, want %0d", event_res, want.ev));
                    if (data_byte !== want.data)
                        flag_error($sformatf("data_byte %h, want %h", data_byte, want.data));
                    if (frame_length !== want.len)
                        flag_error($sformatf("frame_length %0d, want %0d",
                                             frame_length, want.len));
                    if (slot_index !== want.slot)
                        flag_error($sformatf("slot_index %0d, want %0d", slot_index, want.slot));
                    if (last_of_run !== want.last)
                        flag_error($sformatf("last_of_run %b, want %b", last_of_run, want.last));
                end
            end
            if (hold_left != 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (hold_request && !hold_done) begin
                hold_done = 1'b1;
                hold_left = RX_HOLD_CYCLES;
                pop <= 1'b0;
            end else if (pop_gap != 0) begin
                pop_gap--;
                pop <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
                pop_gap = $urandom_range(0, 9);
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic add_word(logic cmd, logic [BYTE_W-1:0] value);
        line_word_t w;
        w.cmd = cmd;
        w.value = value;
        tx_words.push_back(w);
        words_queued++;
    endtask

    task automatic add_byte(logic [BYTE_W-1:0] value);
        add_word(1'b0, value);
    endtask

    // take request; the byte field carries noise
    task automatic add_take();
        add_word(1'b1, BYTE_W'($urandom_range(0, 255)));
    endtask

    // random byte that is neither marker
    function automatic logic [BYTE_W-1:0] pick_payload();
        logic [BYTE_W-1:0] b;
        b = BYTE_W'($urandom_range(0, 255));
        while (b == start_mk || b == end_mk)
            b = BYTE_W'($urandom_range(0, 255));
        return b;
    endfunction

    task automatic add_frame(int n, bit close);
        add_byte(start_mk);
        repeat (n) add_byte(pick_payload());
        if (close)
            add_byte(end_mk);
    endtask

    // random mix of short frames, takes, noise and broken sequences
    task automatic add_line_traffic(int target);
        int base;
        int sel;
        int n;
        base = words_queued;
        while (words_queued - base < target) begin
            sel = $urandom_range(0, 99);
            if (sel < 45) begin
                n = $urandom_range(0, 8);
                add_frame(n, $urandom_range(0, 9) != 0);
            end else if (sel < 70) begin
                repeat ($urandom_range(1, 3)) add_take();
            end else if (sel < 80) begin
                repeat ($urandom_range(1, 4)) add_byte(BYTE_W'($urandom_range(0, 255)));
            end else if (sel < 87) begin
                add_byte(end_mk);
            end else begin
                // restart of an open frame in the same slot
                add_byte(start_mk);
                repeat ($urandom_range(0, 3)) add_byte(pick_payload());
                add_frame($urandom_range(0, 4), 1'b1);
            end
        end
    endtask

    // wait until every word is taken and every result has come
    task automatic wait_idle();
        do
            @(posedge clk);
        while (words_taken != words_queued || pending_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_marker(cfg_reg_t idx, logic [BYTE_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_START_MARKER)
            start_mk = val;
        else
            end_mk = val;
        cfg_valid <= 1'b0;
    endtask

    task automatic set_markers(logic [BYTE_W-1:0] s, logic [BYTE_W-1:0] e);
        write_marker(REG_START_MARKER, s);
        write_marker(REG_END_MARKER, e);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed words on the reset markers
        add_take();                 // empty ring
        add_byte(8'h41);            // data with no open frame
        add_byte(end_mk);           // end with no open frame
        add_frame(0, 1'b1);         // zero-length frame
        add_take();
        add_byte(start_mk);
        add_byte(8'h00);
        add_byte(8'hFF);
        add_byte(8'h55);
        add_byte(8'hAA);
        add_byte(end_mk);
        add_take();
        add_byte(start_mk);
        add_byte(8'h11);
        add_byte(start_mk);         // restart drops the open frame
        add_byte(8'h22);
        add_byte(end_mk);
        add_take();
        add_take();
        wait_idle();

        // overflow with a long receiver hold, the input side fills and stalls
        set_markers(START_MARKER_RST, END_MARKER_RST);
        hold_request = 1'b1;
        add_frame(8, 1'b1);
        add_take();
        add_frame(MAX_FRAME_BYTES + 1, 1'b0);
        add_byte(end_mk);           // nothing open after the overflow
        wait_idle();

        // ring full, suspended receiving and resume
        repeat (SLOT_COUNT) add_frame(0, 1'b1);
        add_frame(1, 1'b1);         // start ignored while suspended
        add_take();
        add_byte(end_mk);           // finds room, receiving resumes
        add_frame(2, 1'b1);
        repeat (SLOT_COUNT + 1) add_take();
        wait_idle();

        // marker extremes
        set_markers(8'h00, 8'hFF);
        add_line_traffic(4);
        wait_idle();
        set_markers(8'hFF, 8'h00);
        add_line_traffic(4);
        wait_idle();

        // equal markers act as end markers only
        set_markers(8'h7E, 8'h7E);
        add_line_traffic(4);
        wait_idle();

        // random distinct markers, no idling on either side
        write_marker(REG_START_MARKER, BYTE_W'($urandom_range(0, 255)));
        write_marker(REG_END_MARKER, start_mk ^ BYTE_W'($urandom_range(1, 255)));
        quiet_tail = 1'b1;
        add_line_traffic(8);
        repeat (3) add_take();

        do
            @(posedge clk);
        while (words_taken != words_queued || pending_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
